### hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/svsm_pkg.sv
// shared types and constants of the servo ramp and pwm tick block
`default_nettype none

package svsm_pkg;

    localparam int CHANNELS     = 16;
    localparam int CH_BITS      = $clog2(CHANNELS);
    localparam int TICK_RANGE   = 4096;
    localparam int TICK_BITS    = $clog2(TICK_RANGE);
    localparam logic [TICK_BITS-1:0] TICK_MAX = TICK_BITS'(TICK_RANGE - 1);

    localparam logic [19:0] US_PER_SECOND = 20'd1000000;

    // quotient bits of the ramp interpolation divider: |diff*k| < 2**14
    localparam int DIV_BITS = 14;

    localparam logic [7:0] HOME_ANGLE_RESET = 8'd90;

    localparam int CFG_ADDR_BITS = 5;

    // register indexes, byte address is 4*index
    localparam logic [2:0] REG_ANGLE_LOW  = 3'd0;
    localparam logic [2:0] REG_ANGLE_HIGH = 3'd1;
    localparam logic [2:0] REG_PULSE_LOW  = 3'd2;
    localparam logic [2:0] REG_PULSE_HIGH = 3'd3;
    localparam logic [2:0] REG_PWM_RATE   = 3'd4;
    localparam logic [2:0] REG_RAMP_STEPS = 3'd5;
    localparam logic [2:0] REG_HOME_ANGLE = 3'd6;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_RAMP  = 1'b1;

    typedef struct packed {
        logic               action;
        logic [CH_BITS-1:0] channel;
        logic [7:0]         angle;
    } cmd_t;

    typedef struct packed {
        logic [CH_BITS-1:0]   out_channel;
        logic [7:0]           out_angle;
        logic [TICK_BITS-1:0] off_ticks;
        logic                 last;
    } res_t;

endpackage

`default_nettype wire

### hdl/servo_smooth_move_pwm_ticks_top.sv
// servo angle command to pwm off-tick converter with linear ramp
//
// cmd channel (cmd_valid/cmd_stall/cmd) takes one command beat: write an angle
// at once, or ramp from the stored angle of the channel to the target.
// res channel (res_valid/res_stall/res) gives one beat for an immediate write
// and ramp_steps+1 beats for a ramp, the final one with last set.
// a command passes through the angle read, for a ramp the multiply and the
// interpolation divider, then the clamp, span, numerator, scale and compare
// states and the tick divider (skipped when the pulse is zero or saturates);
// each later ramp result repeats these from the multiply on. one command is
// worked on at a time, and cmd_stall stays high from accept until its last
// result is in the output register.
// the per-channel angle store is a 16-entry memory with registered read;
// after reset every entry reads as the fixed home angle 90 until first written.
// a stalled result holds in the output register; the next result waits for
// it, while a new command is taken as soon as the last result is registered.
// configuration is an apb-style port, registers at byte address 4*index.
`default_nettype none

module servo_smooth_move_pwm_ticks_top (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cmd_valid,
    output logic                                  cmd_stall,
    input  svsm_pkg::cmd_t                        cmd,
    output logic                                  res_valid,
    input  wire                                   res_stall,
    output svsm_pkg::res_t                        res,
    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire [svsm_pkg::CFG_ADDR_BITS-1:0]     paddr,
    input  wire [31:0]                            pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV,
        S_CLAMP,
        S_SPAN,
        S_NUM,
        S_SCALE,
        S_CMP,
        S_TDIV,
        S_OUT
    } state_t;

    localparam int CB = svsm_pkg::CH_BITS;
    localparam int TB = svsm_pkg::TICK_BITS;

    // configuration registers
    logic [7:0]  angle_low_reg;
    logic [7:0]  angle_high_reg;
    logic [12:0] pulse_low_reg;
    logic [12:0] pulse_high_reg;
    logic [10:0] pwm_rate_reg;
    logic [5:0]  ramp_steps_reg;
    logic [7:0]  home_angle_reg;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_low_reg  <= 8'd0;
            angle_high_reg <= 8'd180;
            pulse_low_reg  <= 13'd500;
            pulse_high_reg <= 13'd2500;
            pwm_rate_reg   <= 11'd50;
            ramp_steps_reg <= 6'd20;
            home_angle_reg <= 8'd90;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                svsm_pkg::REG_ANGLE_LOW:  angle_low_reg  <= pwdata[7:0];
                svsm_pkg::REG_ANGLE_HIGH: angle_high_reg <= pwdata[7:0];
                svsm_pkg::REG_PULSE_LOW:  pulse_low_reg  <= pwdata[12:0];
                svsm_pkg::REG_PULSE_HIGH: pulse_high_reg <= pwdata[12:0];
                svsm_pkg::REG_PWM_RATE:   pwm_rate_reg   <= pwdata[10:0];
                svsm_pkg::REG_RAMP_STEPS: ramp_steps_reg <= pwdata[5:0];
                svsm_pkg::REG_HOME_ANGLE: home_angle_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            svsm_pkg::REG_ANGLE_LOW:  prdata = {24'd0, angle_low_reg};
            svsm_pkg::REG_ANGLE_HIGH: prdata = {24'd0, angle_high_reg};
            svsm_pkg::REG_PULSE_LOW:  prdata = {19'd0, pulse_low_reg};
            svsm_pkg::REG_PULSE_HIGH: prdata = {19'd0, pulse_high_reg};
            svsm_pkg::REG_PWM_RATE:   prdata = {21'd0, pwm_rate_reg};
            svsm_pkg::REG_RAMP_STEPS: prdata = {26'd0, ramp_steps_reg};
            svsm_pkg::REG_HOME_ANGLE: prdata = {24'd0, home_angle_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // angle store memory
    logic [7:0]    store_mem [svsm_pkg::CHANNELS];
    logic [7:0]    rd_data_reg;
    logic          mem_we;
    logic [CB-1:0] mem_waddr;
    logic [7:0]    mem_wdata;

    // written at the edge that loads the last result, read no earlier than
    // the next accept edge, so a following command always sees the new angle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= store_mem[cmd.channel];
    end

    // control and datapath registers
    state_t                     state_reg, state_next;
    svsm_pkg::cmd_t             cmd_reg, cmd_next;
    logic [svsm_pkg::CHANNELS-1:0] store_vld_reg, store_vld_next;
    logic [5:0]                 steps_reg, steps_next;
    logic                       ramp_reg, ramp_next;
    logic [5:0]                 k_reg, k_next;
    logic [7:0]                 start_reg, start_next;
    logic                       neg_reg, neg_next;
    logic [svsm_pkg::DIV_BITS-1:0] quo_reg, quo_next;
    logic [5:0]                 rem_q_reg, rem_q_next;
    logic [3:0]                 cnt_reg, cnt_next;
    logic [7:0]                 angle_reg, angle_next;
    logic signed [8:0]          span_reg, span_next;
    logic signed [22:0]         p1_reg, p1_next;
    logic signed [22:0]         p2_reg, p2_next;
    logic signed [23:0]         num_reg, num_next;
    logic [7:0]                 den_reg, den_next;
    logic                       pos_reg, pos_next;
    logic [33:0]                numrate_reg, numrate_next;
    logic [27:0]                dd_reg, dd_next;
    logic [27:0]                rem_t_reg, rem_t_next;
    logic [TB-1:0]              ticks_reg, ticks_next;
    logic                       res_valid_reg, res_valid_next;
    svsm_pkg::res_t             res_reg, res_next;

    // combinational temporaries
    logic                       is_ramp;
    logic signed [8:0]          diff;
    logic signed [7:0]          k_sig;
    logic signed [15:0]         prod;
    logic [15:0]                mag;
    logic [6:0]                 rsh;
    logic [6:0]                 rsh_sub;
    logic signed [15:0]         ofs;
    logic signed [15:0]         a_raw;
    logic signed [8:0]          span;
    logic signed [13:0]         pl_sig;
    logic signed [8:0]          adiff;
    logic signed [13:0]         pdiff;
    logic signed [23:0]         sum;
    logic signed [8:0]          span_neg;
    logic [28:0]                r2;
    logic [28:0]                r2_sub;
    logic                       last;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        store_vld_next = store_vld_reg;
        steps_next     = steps_reg;
        ramp_next      = ramp_reg;
        k_next         = k_reg;
        start_next     = start_reg;
        neg_next       = neg_reg;
        quo_next       = quo_reg;
        rem_q_next     = rem_q_reg;
        cnt_next       = cnt_reg;
        angle_next     = angle_reg;
        span_next      = span_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        pos_next       = pos_reg;
        numrate_next   = numrate_reg;
        dd_next        = dd_reg;
        rem_t_next     = rem_t_reg;
        ticks_next     = ticks_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = cmd_reg.channel;
        mem_wdata      = angle_reg;

        is_ramp  = 1'b0;
        diff     = '0;
        k_sig    = '0;
        prod     = '0;
        mag      = '0;
        rsh      = '0;
        rsh_sub  = '0;
        ofs      = '0;
        a_raw    = '0;
        span     = '0;
        pl_sig   = '0;
        adiff    = '0;
        pdiff    = '0;
        sum      = '0;
        span_neg = '0;
        r2       = '0;
        r2_sub   = '0;
        last     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    steps_next = ramp_steps_reg;
                    state_next = S_READ;
                end
            end

            S_READ:
            begin
                start_next = store_vld_reg[cmd_reg.channel] ? rd_data_reg
                                                            : svsm_pkg::HOME_ANGLE_RESET;
                is_ramp    = (cmd_reg.action == svsm_pkg::ACT_RAMP) && (steps_reg != 6'd0);
                ramp_next  = is_ramp;
                k_next     = 6'd0;
                state_next = is_ramp ? S_MUL : S_CLAMP;
            end

            S_MUL:
            begin
                diff       = $signed({1'b0, cmd_reg.angle}) - $signed({1'b0, start_reg});
                k_sig      = $signed({2'b0, k_reg});
                prod       = 16'(diff) * 16'(k_sig);
                mag        = prod[15] ? 16'(-prod) : 16'(prod);
                neg_next   = prod[15];
                quo_next   = mag[svsm_pkg::DIV_BITS-1:0];
                rem_q_next = 6'd0;
                cnt_next   = 4'd0;
                state_next = S_DIV;
            end

            // restoring divide of |diff*k| by steps, one quotient bit a cycle
            S_DIV:
            begin
                rsh = {rem_q_reg, quo_reg[svsm_pkg::DIV_BITS-1]};
                if (rsh >= {1'b0, steps_reg})
                begin
                    rsh_sub    = rsh - {1'b0, steps_reg};
                    rem_q_next = rsh_sub[5:0];
                    quo_next   = {quo_reg[svsm_pkg::DIV_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_q_next = rsh[5:0];
                    quo_next   = {quo_reg[svsm_pkg::DIV_BITS-2:0], 1'b0};
                end
                if (cnt_reg == 4'(svsm_pkg::DIV_BITS - 1))
                begin
                    state_next = S_CLAMP;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end

            S_CLAMP:
            begin
                if (ramp_reg)
                begin
                    ofs   = neg_reg ? -$signed({2'b0, quo_reg}) : $signed({2'b0, quo_reg});
                    a_raw = $signed({8'b0, start_reg}) + ofs;
                end
                else
                begin
                    a_raw = $signed({8'b0, cmd_reg.angle});
                end
                // low limit is tested first, matters when the limits are inverted
                if (a_raw < $signed({8'b0, angle_low_reg}))
                begin
                    angle_next = angle_low_reg;
                end
                else if (a_raw > $signed({8'b0, angle_high_reg}))
                begin
                    angle_next = angle_high_reg;
                end
                else
                begin
                    angle_next = a_raw[7:0];
                end
                state_next = S_SPAN;
            end

            S_SPAN:
            begin
                span       = $signed({1'b0, angle_high_reg}) - $signed({1'b0, angle_low_reg});
                pl_sig     = $signed({1'b0, pulse_low_reg});
                adiff      = $signed({1'b0, angle_reg}) - $signed({1'b0, angle_low_reg});
                pdiff      = $signed({1'b0, pulse_high_reg}) - pl_sig;
                span_next  = span;
                p1_next    = 23'(pl_sig) * 23'(span);
                p2_next    = 23'(adiff) * 23'(pdiff);
                state_next = S_NUM;
            end

            S_NUM:
            begin
                sum = $signed({p1_reg[22], p1_reg}) + $signed({p2_reg[22], p2_reg});
                if (span_reg == 9'sd0)
                begin
                    num_next = $signed({11'b0, pulse_low_reg});
                    den_next = 8'd1;
                end
                else if (span_reg[8])
                begin
                    span_neg = -span_reg;
                    num_next = -sum;
                    den_next = span_neg[7:0];
                end
                else
                begin
                    num_next = sum;
                    den_next = span_reg[7:0];
                end
                state_next = S_SCALE;
            end

            S_SCALE:
            begin
                pos_next     = !num_reg[23] && (num_reg != 24'sd0);
                numrate_next = 34'(num_reg[22:0]) * 34'(pwm_rate_reg);
                dd_next      = 28'(den_reg) * 28'(svsm_pkg::US_PER_SECOND);
                state_next   = S_CMP;
            end

            // ticks = floor(numrate*TICK_RANGE/dd); saturates once numrate >= dd
            S_CMP:
            begin
                ticks_next = '0;
                cnt_next   = 4'd0;
                if (!pos_reg)
                begin
                    state_next = S_OUT;
                end
                else if (numrate_reg >= {6'b0, dd_reg})
                begin
                    ticks_next = svsm_pkg::TICK_MAX;
                    state_next = S_OUT;
                end
                else
                begin
                    rem_t_next = numrate_reg[27:0];
                    state_next = S_TDIV;
                end
            end

            S_TDIV:
            begin
                r2 = {rem_t_reg, 1'b0};
                if (r2 >= {1'b0, dd_reg})
                begin
                    r2_sub     = r2 - {1'b0, dd_reg};
                    rem_t_next = r2_sub[27:0];
                    ticks_next = {ticks_reg[TB-2:0], 1'b1};
                end
                else
                begin
                    rem_t_next = r2[27:0];
                    ticks_next = {ticks_reg[TB-2:0], 1'b0};
                end
                if (cnt_reg == 4'(TB - 1))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end

            S_OUT:
            begin
                last = !ramp_reg || (k_reg == steps_reg);
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next       = 1'b1;
                    res_next.out_channel = cmd_reg.channel;
                    res_next.out_angle   = angle_reg;
                    res_next.off_ticks   = ticks_reg;
                    res_next.last        = last;
                    if (last)
                    begin
                        mem_we                          = 1'b1;
                        store_vld_next[cmd_reg.channel] = 1'b1;
                        state_next                      = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 6'd1;
                        state_next = S_MUL;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            store_vld_reg <= '0;
            steps_reg     <= '0;
            ramp_reg      <= 1'b0;
            k_reg         <= '0;
            start_reg     <= '0;
            neg_reg       <= 1'b0;
            quo_reg       <= '0;
            rem_q_reg     <= '0;
            cnt_reg       <= '0;
            angle_reg     <= '0;
            span_reg      <= '0;
            p1_reg        <= '0;
            p2_reg        <= '0;
            num_reg       <= '0;
            den_reg       <= '0;
            pos_reg       <= 1'b0;
            numrate_reg   <= '0;
            dd_reg        <= '0;
            rem_t_reg     <= '0;
            ticks_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            store_vld_reg <= store_vld_next;
            steps_reg     <= steps_next;
            ramp_reg      <= ramp_next;
            k_reg         <= k_next;
            start_reg     <= start_next;
            neg_reg       <= neg_next;
            quo_reg       <= quo_next;
            rem_q_reg     <= rem_q_next;
            cnt_reg       <= cnt_next;
            angle_reg     <= angle_next;
            span_reg      <= span_next;
            p1_reg        <= p1_next;
            p2_reg        <= p2_next;
            num_reg       <= num_next;
            den_reg       <= den_next;
            pos_reg       <= pos_next;
            numrate_reg   <= numrate_next;
            dd_reg        <= dd_next;
            rem_t_reg     <= rem_t_next;
            ticks_reg     <= ticks_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

### hdl/svsm_checker.sv
// port-level checker of the servo ramp block and its bind
`default_nettype none

`include "assert_macros.svh"

module svsm_checker (
    input wire                                clk,
    input wire                                rst_n,
    input wire                                cmd_valid,
    input wire                                cmd_stall,
    input wire                                res_valid,
    input wire                                res_stall,
    input svsm_pkg::res_t                     res,
    input wire                                psel,
    input wire                                pwrite,
    input wire [svsm_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input wire [31:0]                         prdata
);

    // a stalled result beat holds
    `ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid && $stable(res), "result beat changed while stalled")

    // one command at a time: the cycle after an accept the command side stalls
    `ASSERT_NEXT(a_cmd_busy, clk, rst_n, cmd_valid && !cmd_stall, cmd_stall, "command accepted while a command is in work")

    // reads beyond the register list return zero
    `ASSERT_IMPLIES(a_rd_spare, clk, rst_n, psel && !pwrite && (paddr[4:2] > svsm_pkg::REG_HOME_ANGLE), prdata == 32'd0, "nonzero read of an unused register")

endmodule

bind servo_smooth_move_pwm_ticks_top svsm_checker u_svsm_checker (.*);

`default_nettype wire
